/* sv/sms_pkg.sv */
// shared types and constants for the spi master shifter
package sms_pkg;

  localparam int WORD_BITS_DEF  = 8;
  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int HALF_PERIOD_W = 16;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SELECT  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_START   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_BOTH  = 2'd2,
    KIND_ALIAS = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CLOCK_POLARITY = 3'd0,
    REG_CLOCK_PHASE    = 3'd1,
    REG_MSB_FIRST      = 3'd2,
    REG_THREE_WIRE     = 3'd3,
    REG_HALF_PERIOD    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic                     clock_polarity;
    logic                     clock_phase;
    logic                     msb_first;
    logic                     three_wire;
    logic [HALF_PERIOD_W-1:0] half_period;
  } cfg_t;

  typedef struct packed {
    logic sclk;
    logic sdo;
    logic sdo_enable;
    logic cs_n;
    logic rx_done;
    logic busy_res;
  } pins_t;

endpackage

/* sv/sms_if.sv */
// item channels: operations in, pin results out
interface spi_cmd_if #(parameter int WORD_BITS = 8);
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [WORD_BITS-1:0] tx_byte;
  logic [1:0]           xfer_kind;
  logic                 sdi;

  modport source (output valid, output op, output tx_byte, output xfer_kind,
                  output sdi, input ready);
  modport sink (input valid, input op, input tx_byte, input xfer_kind,
                input sdi, output ready);
endinterface

interface spi_res_if #(parameter int WORD_BITS = 8);
  logic                 valid;
  logic                 ready;
  logic                 sclk;
  logic                 sdo;
  logic                 sdo_enable;
  logic                 cs_n;
  logic [WORD_BITS-1:0] rx_byte;
  logic                 rx_done;
  logic                 busy_res;

  modport source (output valid, output sclk, output sdo, output sdo_enable,
                  output cs_n, output rx_byte, output rx_done, output busy_res,
                  input ready);
  modport sink (input valid, input sclk, input sdo, input sdo_enable,
                input cs_n, input rx_byte, input rx_done, input busy_res,
                output ready);
endinterface

/* sv/sms_cfg.sv */
// configuration register bank
module sms_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sms_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sms_pkg::CFG_DATA_W-1:0]    cfg_data,
  output sms_pkg::cfg_t                     cfg
);
  import sms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_polarity <= 1'b0;
      cfg.clock_phase    <= 1'b0;
      cfg.msb_first      <= 1'b1;
      cfg.three_wire     <= 1'b0;
      cfg.half_period    <= HALF_PERIOD_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK_POLARITY: cfg.clock_polarity <= cfg_data[0];
        REG_CLOCK_PHASE:    cfg.clock_phase    <= cfg_data[0];
        REG_MSB_FIRST:      cfg.msb_first      <= cfg_data[0];
        REG_THREE_WIRE:     cfg.three_wire     <= cfg_data[0];
        REG_HALF_PERIOD:    cfg.half_period    <= cfg_data[HALF_PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/sms_core.sv */
// shifter and clock divider state with its one-item update
module sms_core #(
  parameter int WORD_BITS  = sms_pkg::WORD_BITS_DEF,
  parameter int TIMER_BITS = sms_pkg::TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  sms_pkg::cfg_t        cfg,
  input  logic [1:0]           op,
  input  logic [WORD_BITS-1:0] tx_byte,
  input  logic [1:0]           xfer_kind,
  input  logic                 sdi,
  output sms_pkg::pins_t       pins,
  output logic [WORD_BITS-1:0] rx_byte
);
  import sms_pkg::*;

  localparam int BL_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0]  out_shift, out_shift_next;
  logic [WORD_BITS-1:0]  in_shift, in_shift_next;
  logic [BL_W-1:0]       bits_left, bits_left_next;
  logic                  half_phase, half_phase_next;
  logic [TIMER_BITS-1:0] tick_count, tick_count_next;
  logic                  select_level, select_level_next;
  logic                  clock_level, clock_level_next;
  logic                  data_level, data_level_next;
  logic                  drive_enable, drive_enable_next;
  kind_t                 transfer_kind, transfer_kind_next;
  logic                  active, active_next;
  logic                  done;

  logic [TIMER_BITS-1:0] hp_raw, hp, tick_inc;
  kind_t                 kind_in;

  function automatic logic [WORD_BITS-1:0] shift_out(input logic [WORD_BITS-1:0] s,
                                                     input logic msb);
    logic [WORD_BITS-1:0] r;
    r = msb ? {s[WORD_BITS-2:0], 1'b0} : {1'b0, s[WORD_BITS-1:1]};
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] shift_in(input logic [WORD_BITS-1:0] s,
                                                    input logic b, input logic msb);
    logic [WORD_BITS-1:0] r;
    r = msb ? {s[WORD_BITS-2:0], b} : {b, s[WORD_BITS-1:1]};
    return r;
  endfunction

  assign hp_raw   = TIMER_BITS'(cfg.half_period);
  assign hp       = (hp_raw == '0) ? TIMER_BITS'(1) : hp_raw;
  assign tick_inc = tick_count + TIMER_BITS'(1);
  assign kind_in  = (kind_t'(xfer_kind) == KIND_ALIAS) ? KIND_BOTH : kind_t'(xfer_kind);

  always_comb begin
    out_shift_next     = out_shift;
    in_shift_next      = in_shift;
    bits_left_next     = bits_left;
    half_phase_next    = half_phase;
    tick_count_next    = tick_count;
    select_level_next  = select_level;
    clock_level_next   = clock_level;
    data_level_next    = data_level;
    drive_enable_next  = drive_enable;
    transfer_kind_next = transfer_kind;
    active_next        = active;
    done               = 1'b0;

    unique case (op_t'(op))
      OP_SELECT:  select_level_next = 1'b0;
      OP_RELEASE: select_level_next = 1'b1;
      OP_START: begin
        if (!active) begin
          transfer_kind_next = kind_in;
          in_shift_next      = '0;
          bits_left_next     = BL_W'(WORD_BITS);
          half_phase_next    = 1'b0;
          tick_count_next    = '0;
          clock_level_next   = cfg.clock_polarity;
          drive_enable_next  = !(cfg.three_wire && kind_in == KIND_READ);
          active_next        = 1'b1;
          // mode 0/2 puts the first bit out before the leading edge
          if (!cfg.clock_phase && kind_in != KIND_READ) begin
            data_level_next = cfg.msb_first ? tx_byte[WORD_BITS-1] : tx_byte[0];
            out_shift_next  = shift_out(tx_byte, cfg.msb_first);
          end else begin
            out_shift_next = tx_byte;
          end
        end
      end
      OP_TICK: begin
        if (active) begin
          tick_count_next = tick_inc;
          if (tick_inc >= hp) begin
            tick_count_next = '0;
            if (!half_phase) begin
              // leading edge
              clock_level_next = !cfg.clock_polarity;
              half_phase_next  = 1'b1;
              if (!cfg.clock_phase) begin
                if (transfer_kind != KIND_WRITE)
                  in_shift_next = shift_in(in_shift, sdi, cfg.msb_first);
              end else if (transfer_kind != KIND_READ) begin
                data_level_next = cfg.msb_first ? out_shift[WORD_BITS-1] : out_shift[0];
                out_shift_next  = shift_out(out_shift, cfg.msb_first);
              end
            end else begin
              // trailing edge
              clock_level_next = cfg.clock_polarity;
              half_phase_next  = 1'b0;
              if (!cfg.clock_phase) begin
                if (transfer_kind != KIND_READ && bits_left > BL_W'(1)) begin
                  data_level_next = cfg.msb_first ? out_shift[WORD_BITS-1] : out_shift[0];
                  out_shift_next  = shift_out(out_shift, cfg.msb_first);
                end
              end else if (transfer_kind != KIND_WRITE) begin
                in_shift_next = shift_in(in_shift, sdi, cfg.msb_first);
              end
              if (bits_left != '0)
                bits_left_next = bits_left - BL_W'(1);
              if (bits_left <= BL_W'(1)) begin
                active_next = 1'b0;
                done        = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (!active_next)
      clock_level_next = cfg.clock_polarity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_shift     <= '0;
      in_shift      <= '0;
      bits_left     <= '0;
      half_phase    <= 1'b0;
      tick_count    <= '0;
      select_level  <= 1'b1;
      clock_level   <= 1'b0;
      data_level    <= 1'b1;
      drive_enable  <= 1'b1;
      transfer_kind <= KIND_WRITE;
      active        <= 1'b0;
    end else if (step) begin
      out_shift     <= out_shift_next;
      in_shift      <= in_shift_next;
      bits_left     <= bits_left_next;
      half_phase    <= half_phase_next;
      tick_count    <= tick_count_next;
      select_level  <= select_level_next;
      clock_level   <= clock_level_next;
      data_level    <= data_level_next;
      drive_enable  <= drive_enable_next;
      transfer_kind <= transfer_kind_next;
      active        <= active_next;
    end
  end

  always_comb begin
    pins.sclk       = clock_level_next;
    pins.sdo        = data_level_next;
    pins.sdo_enable = drive_enable_next;
    pins.cs_n       = select_level_next;
    pins.rx_done    = done;
    pins.busy_res   = active_next;
    rx_byte         = done ? in_shift_next : '0;
  end

endmodule

/* sv/spi_master_shifter_unit.sv */
// SPI master shifter. Each operation item (tick, select, release, start) is taken
// into an input register and then, once the result register is free or being taken,
// updates the shifter and divider state and loads the result register, so one item is
// accepted every clock cycle while results are taken without a wait. The result
// register is refilled in the same cycle it is taken, and the input register only
// holds while a result waits downstream. Serial clock timing is counted in tick
// items, half_period ticks per half clock; configuration writes apply immediately.
module spi_master_shifter_unit #(
  parameter int WORD_BITS  = sms_pkg::WORD_BITS_DEF,
  parameter int TIMER_BITS = sms_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sms_pkg::CFG_DATA_W-1:0]  cfg_data,
  spi_cmd_if.sink                         cmd,
  spi_res_if.source                       res
);
  import sms_pkg::*;

  cfg_t                 cfg;
  pins_t                pins;
  logic [WORD_BITS-1:0] rx_word;

  logic                 stage_valid;
  logic [1:0]           stage_op;
  logic [WORD_BITS-1:0] stage_tx;
  logic [1:0]           stage_kind;
  logic                 stage_sdi;
  logic                 advance;

  logic                 res_valid;
  pins_t                res_pins;
  logic [WORD_BITS-1:0] res_rx;

  sms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sms_core #(
    .WORD_BITS  (WORD_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cfg       (cfg),
    .op        (stage_op),
    .tx_byte   (stage_tx),
    .xfer_kind (stage_kind),
    .sdi       (stage_sdi),
    .pins      (pins),
    .rx_byte   (rx_word)
  );

  // staged item moves on whenever the result register is free or being taken
  assign advance   = stage_valid && (!res_valid || res.ready);
  assign cmd.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      stage_op   <= cmd.op;
      stage_tx   <= cmd.tx_byte;
      stage_kind <= cmd.xfer_kind;
      stage_sdi  <= cmd.sdi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_pins <= pins;
      res_rx   <= rx_word;
    end
  end

  assign res.valid      = res_valid;
  assign res.sclk       = res_pins.sclk;
  assign res.sdo        = res_pins.sdo;
  assign res.sdo_enable = res_pins.sdo_enable;
  assign res.cs_n       = res_pins.cs_n;
  assign res.rx_byte    = res_rx;
  assign res.rx_done    = res_pins.rx_done;
  assign res.busy_res   = res_pins.busy_res;

endmodule

/* verif/spi_master_shifter_unit_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for spi_master_shifter_unit: directed and random operation items
module spi_master_shifter_unit_test;
  import sms_pkg::*;

  localparam int BITS = WORD_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 70;
  localparam int FIRST_SPARE_REG = REG_HALF_PERIOD + 1;
  localparam int REG_SLOTS = 1 << CFG_INDEX_W;

  typedef struct packed {
    logic            sclk;
    logic            sdo;
    logic            sdo_enable;
    logic            cs_n;
    logic [BITS-1:0] rx_byte;
    logic            rx_done;
    logic            busy_res;
  } pin_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spi_cmd_if #(.WORD_BITS(BITS)) cmd_ch ();
  spi_res_if #(.WORD_BITS(BITS)) res_ch ();

  spi_master_shifter_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shifter configuration as the block should see it
  logic                     cf_polarity, cf_phase, cf_msb_first, cf_three_wire;
  logic [HALF_PERIOD_W-1:0] cf_half_period;

  // shifter state
  logic [BITS-1:0]           sh_out, sh_in;
  logic [3:0]                sh_bits_left;
  logic                      sh_half, sh_select, sh_clock, sh_data, sh_drive, sh_active;
  logic [TIMER_BITS_DEF-1:0] sh_ticks;
  kind_t                     sh_kind;

  pin_result_t expected_pins[$];
  int errors = 0;
  int results_checked = 0;
  int transfers_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit gaps_off = 1'b0;

  function automatic void shift_out_bit();
    if (cf_msb_first) begin
      sh_data = sh_out[BITS-1];
      sh_out  = sh_out << 1;
    end else begin
      sh_data = sh_out[0];
      sh_out  = sh_out >> 1;
    end
  endfunction

  function automatic void shift_in_bit(logic bit_in);
    if (cf_msb_first) sh_in = {sh_in[BITS-2:0], bit_in};
    else sh_in = {bit_in, sh_in[BITS-1:1]};
  endfunction

  function automatic pin_result_t step_shifter(op_t op, logic [BITS-1:0] tx, kind_t kind,
                                               logic sdi);
    pin_result_t r;
    logic [HALF_PERIOD_W-1:0] hp;
    logic done;
    hp = (cf_half_period == '0) ? HALF_PERIOD_W'(1) : cf_half_period;
    done = 1'b0;
    case (op)
      OP_SELECT: sh_select = 1'b0;
      OP_RELEASE: sh_select = 1'b1;
      OP_START: begin
        if (!sh_active) begin
          sh_kind      = (kind == KIND_ALIAS) ? KIND_BOTH : kind;
          sh_out       = tx;
          sh_in        = '0;
          sh_bits_left = 4'(BITS);
          sh_half      = 1'b0;
          sh_ticks     = '0;
          sh_clock     = cf_polarity;
          sh_drive     = !(cf_three_wire && sh_kind == KIND_READ);
          sh_active    = 1'b1;
          if (!cf_phase && sh_kind != KIND_READ) shift_out_bit();
        end
      end
      default: begin
        if (sh_active) begin
          sh_ticks = sh_ticks + 1'b1;
          if (sh_ticks >= hp) begin
            sh_ticks = '0;
            if (!sh_half) begin
              // leading edge
              sh_clock = !cf_polarity;
              if (!cf_phase) begin
                if (sh_kind != KIND_WRITE) shift_in_bit(sdi);
              end else if (sh_kind != KIND_READ) begin
                shift_out_bit();
              end
              sh_half = 1'b1;
            end else begin
              // trailing edge, last bit is not followed by a new drive in phase 0
              sh_clock = cf_polarity;
              if (!cf_phase) begin
                if (sh_kind != KIND_READ && sh_bits_left > 4'd1) shift_out_bit();
              end else if (sh_kind != KIND_WRITE) begin
                shift_in_bit(sdi);
              end
              sh_half = 1'b0;
              if (sh_bits_left > 4'd0) sh_bits_left = sh_bits_left - 1'b1;
              if (sh_bits_left == 4'd0) begin
                sh_active = 1'b0;
                done = 1'b1;
              end
            end
          end
        end
      end
    endcase
    if (!sh_active) sh_clock = cf_polarity;
    r.sclk       = sh_clock;
    r.sdo        = sh_data;
    r.sdo_enable = sh_drive;
    r.cs_n       = sh_select;
    r.rx_byte    = done ? sh_in : '0;
    r.rx_done    = done;
    r.busy_res   = sh_active;
    return r;
  endfunction

  function automatic void check_field(string name, logic [BITS-1:0] want, logic [BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // result check, register writes and prediction, in that order at each edge
  always @(posedge clk) begin
    pin_result_t want;
    if (rst) begin
      cf_polarity = 1'b0; cf_phase = 1'b0; cf_msb_first = 1'b1; cf_three_wire = 1'b0;
      cf_half_period = HALF_PERIOD_W'(1);
      sh_out = '0; sh_in = '0; sh_bits_left = '0; sh_half = 1'b0; sh_ticks = '0;
      sh_select = 1'b1; sh_clock = 1'b0; sh_data = 1'b1; sh_drive = 1'b1;
      sh_kind = KIND_WRITE; sh_active = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_pins.size() == 0) begin
          errors++;
          $display("%0t: result item with nothing expected", $time);
        end else begin
          want = expected_pins.pop_front();
          check_field("sclk", BITS'(want.sclk), BITS'(res_ch.sclk));
          check_field("sdo", BITS'(want.sdo), BITS'(res_ch.sdo));
          check_field("sdo_enable", BITS'(want.sdo_enable), BITS'(res_ch.sdo_enable));
          check_field("cs_n", BITS'(want.cs_n), BITS'(res_ch.cs_n));
          check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
          check_field("rx_done", BITS'(want.rx_done), BITS'(res_ch.rx_done));
          check_field("busy_res", BITS'(want.busy_res), BITS'(res_ch.busy_res));
          results_checked++;
          if (want.rx_done) transfers_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOCK_POLARITY: cf_polarity = cfg_data[0];
          REG_CLOCK_PHASE: cf_phase = cfg_data[0];
          REG_MSB_FIRST: cf_msb_first = cfg_data[0];
          REG_THREE_WIRE: cf_three_wire = cfg_data[0];
          REG_HALF_PERIOD: cf_half_period = cfg_data[HALF_PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_ch.valid && cmd_ch.ready)
        expected_pins.push_back(step_shifter(op_t'(cmd_ch.op), cmd_ch.tx_byte,
                                             kind_t'(cmd_ch.xfer_kind), cmd_ch.sdi));
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("spi_master_shifter_unit regression: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  initial begin
    int burst, gap;
    res_ch.ready <= 1'b1;
    forever begin
      burst = $urandom_range(1, 24);
      repeat (burst) @(posedge clk);
      gap = gaps_off ? 0 : pick_gap();
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(op_t op, logic [BITS-1:0] tx, kind_t kind, logic sdi);
    int gap;
    gap = gaps_off ? 0 : pick_gap();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.op        <= op;
    cmd_ch.tx_byte   <= tx;
    cmd_ch.xfer_kind <= kind;
    cmd_ch.sdi       <= sdi;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(OP_TICK, BITS'($urandom), kind_t'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_op();
    send_item(op_t'($urandom_range(1, 3)), BITS'($urandom), kind_t'($urandom_range(0, 3)),
              1'($urandom_range(0, 1)));
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // single-bit registers get random upper bits, which must be ignored
  task automatic set_mode(logic pol, logic pha, logic msb, logic three,
                          logic [HALF_PERIOD_W-1:0] hp);
    logic [CFG_DATA_W-1:0] pad;
    pad = CFG_DATA_W'($urandom);
    write_reg(REG_CLOCK_POLARITY, {pad[CFG_DATA_W-1:1], pol});
    pad = CFG_DATA_W'($urandom);
    write_reg(REG_CLOCK_PHASE, {pad[CFG_DATA_W-1:1], pha});
    pad = CFG_DATA_W'($urandom);
    write_reg(REG_MSB_FIRST, {pad[CFG_DATA_W-1:1], msb});
    pad = CFG_DATA_W'($urandom);
    write_reg(REG_THREE_WIRE, {pad[CFG_DATA_W-1:1], three});
    write_reg(REG_HALF_PERIOD, hp);
  endtask

  // ticks that one whole byte needs at the current rate
  function automatic int byte_ticks();
    return 2 * BITS * ((cf_half_period == '0) ? 1 : int'(cf_half_period));
  endfunction

  task automatic run_transfer(logic [BITS-1:0] tx, kind_t kind, bit with_noise);
    int n;
    if ($urandom_range(0, 99) < 85)
      send_item(OP_SELECT, BITS'($urandom), kind, 1'($urandom_range(0, 1)));
    send_item(OP_START, tx, kind, 1'($urandom_range(0, 1)));
    n = byte_ticks() + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if (with_noise && $urandom_range(0, 99) < 5) send_random_op();
      send_ticks(1);
    end
    if ($urandom_range(0, 99) < 85)
      send_item(OP_RELEASE, BITS'($urandom), kind, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_state();
    send_ticks(2);
    send_item(OP_SELECT, 8'h00, KIND_WRITE, 1'b0);
    send_item(OP_START, 8'hA5, KIND_BOTH, 1'b1);
    send_ticks(8);
    // start while busy and chip select changes must not disturb the running byte
    send_item(OP_START, 8'h3C, KIND_WRITE, 1'b1);
    send_item(OP_RELEASE, 8'hFF, KIND_READ, 1'b0);
    send_item(OP_SELECT, 8'hFF, KIND_ALIAS, 1'b1);
    send_ticks(9);
    send_item(OP_RELEASE, 8'h00, KIND_WRITE, 1'b0);
    settle();
  endtask

  task automatic test_field_extremes();
    set_mode(1'b1, 1'b1, 1'b0, 1'b1, '0);
    run_transfer(8'h00, KIND_READ, 1'b0);
    run_transfer(8'hFF, KIND_ALIAS, 1'b0);
    settle();
    set_mode(1'b0, 1'b1, 1'b1, 1'b1, HALF_PERIOD_W'(2));
    run_transfer(BITS'($urandom), KIND_WRITE, 1'b0);
    run_transfer(BITS'($urandom), KIND_READ, 1'b0);
    settle();
  endtask

  // very slow clock, then speed and polarity changed with the byte still running
  task automatic test_slow_clock_retune();
    set_mode(1'b0, 1'b0, 1'b1, 1'b0, '1);
    send_item(OP_SELECT, BITS'($urandom), KIND_BOTH, 1'b0);
    send_item(OP_START, BITS'($urandom), KIND_BOTH, 1'b1);
    send_ticks(40);
    settle();
    write_reg(REG_HALF_PERIOD, CFG_DATA_W'(1));
    write_reg(REG_CLOCK_POLARITY, CFG_DATA_W'(1));
    send_ticks(2 * BITS + 2);
    send_item(OP_RELEASE, BITS'($urandom), KIND_BOTH, 1'b0);
    settle();
  endtask

  task automatic test_spare_registers();
    set_mode(1'b0, 1'b0, 1'b0, 1'b0, HALF_PERIOD_W'(1));
    for (int idx = FIRST_SPARE_REG; idx < REG_SLOTS; idx++)
      write_reg(CFG_INDEX_W'(idx), CFG_DATA_W'($urandom));
    run_transfer(BITS'($urandom), KIND_BOTH, 1'b0);
    settle();
  endtask

  task automatic test_random_modes();
    int r, first_item;
    logic [HALF_PERIOD_W-1:0] hp;
    for (int mode = 0; mode < 16; mode++) begin
      r = $urandom_range(0, 99);
      if (r < 45) hp = HALF_PERIOD_W'(1);
      else if (r < 70) hp = HALF_PERIOD_W'(2);
      else if (r < 85) hp = '0;
      else hp = HALF_PERIOD_W'($urandom_range(3, 5));
      set_mode(mode[0], mode[1], mode[2], mode[3], hp);
      gaps_off = (mode % 5 == 3);
      first_item = items_sent;
      while (items_sent - first_item < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          run_transfer(BITS'($urandom), kind_t'($urandom_range(0, 3)), 1'b1);
        end else if (r < 90) begin
          // cut short: the next start is ignored and its ticks finish this byte
          send_item(OP_START, BITS'($urandom), kind_t'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)));
          send_ticks($urandom_range(0, byte_ticks()));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) send_random_op();
            else send_ticks(1);
          end
        end
      end
      settle();
      gaps_off = 1'b0;
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_CLOCK_POLARITY;
    cfg_data         <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.op        <= OP_TICK;
    cmd_ch.tx_byte   <= '0;
    cmd_ch.xfer_kind <= KIND_WRITE;
    cmd_ch.sdi       <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_slow_clock_retune();
    test_spare_registers();
    test_random_modes();

    repeat (10) @(posedge clk);
    if (expected_pins.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_pins.size());
    end
    $display("covered: %0d operation items sent, %0d results checked, %0d bytes completed",
             items_sent, results_checked, transfers_seen);
    $display("all four clock modes, both bit orders, 3-wire and 4-wire, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("spi_master_shifter_unit regression: pass");
    end else begin
      $display("spi_master_shifter_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sms_pkg.sv
sv/sms_if.sv
sv/sms_cfg.sv
sv/sms_core.sv
sv/spi_master_shifter_unit.sv
verif/spi_master_shifter_unit_test.sv
